@@ design/pair_frequency_table_macros.svh @@
// ---------------------------------------------------------------------------
// Pair frequency table assertion macros
// Shared property shorthands for the checker of the pair counter block.
// ---------------------------------------------------------------------------
`ifndef PAIR_FREQUENCY_TABLE_MACROS_SVH
`define PAIR_FREQUENCY_TABLE_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define PFT_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is held.
`define PFT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/pft_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Pair frequency table package
// Field widths, defaults, shared types and helpers for the pair counter block.
// ---------------------------------------------------------------------------
package pft_pkg;

    localparam int ID_W                = 8;
    localparam int INC_W               = 16;
    localparam int CFG_W               = 9;
    localparam int DEFAULT_MAX_ITEMS   = 256;
    localparam int DEFAULT_COUNT_WIDTH = 31;

    localparam logic [CFG_W-1:0] ITEM_COUNT_RESET = 9'd256;

    // Classification carried from the front end to the back end with each job
    typedef struct packed {
        logic             bad;
        logic [INC_W-1:0] increment;
    } pft_tag_t;

    typedef enum logic [1:0] {
        BACK_CLEAR,
        BACK_IDLE,
        BACK_UPDATE
    } pft_back_state_t;

    function automatic int pft_addr_width(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

@@ design/pft_ram.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Pair frequency table RAM
// Generic memory with one write port and one registered read port.
// ---------------------------------------------------------------------------
module pft_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 32640
) (
    input  logic                                    aclk,
    input  logic                                    wr_en,
    input  logic [pft_pkg::pft_addr_width(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [pft_pkg::pft_addr_width(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);
    import pft_pkg::*;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/pft_front.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Pair frequency table front end
// Holds the item count, orders each pair, checks it and computes its slot.
// ---------------------------------------------------------------------------
module pft_front #(
    parameter int MAX_ITEMS = pft_pkg::DEFAULT_MAX_ITEMS
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // configuration
    input  logic                       cfg_valid,
    input  logic [pft_pkg::CFG_W-1:0]  cfg_data,
    // input items
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [pft_pkg::ID_W-1:0]   s_first_id,
    input  logic [pft_pkg::ID_W-1:0]   s_second_id,
    input  logic [pft_pkg::INC_W-1:0]  s_increment,
    // back end busy with its clearing pass
    input  logic                       clear_busy,
    // classified jobs
    output logic                       job_valid,
    input  logic                       job_ready,
    output pft_pkg::pft_tag_t          job_tag,
    output logic [pft_pkg::pft_addr_width(MAX_ITEMS * (MAX_ITEMS - 1) / 2)-1:0] job_slot
);
    import pft_pkg::*;

    localparam int TABLE_DEPTH = MAX_ITEMS * (MAX_ITEMS - 1) / 2;
    localparam int SLOT_W      = pft_addr_width(TABLE_DEPTH);
    localparam int PROD_W      = 2 * ID_W + 2;

    logic [CFG_W-1:0]  item_count_reg;
    logic              job_valid_reg, job_valid_next;
    pft_tag_t          tag_reg, tag_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;

    logic              accept;
    logic [CFG_W-1:0]  n_eff;
    logic [ID_W-1:0]   lo, hi;
    logic [CFG_W:0]    row_span;
    logic [PROD_W-1:0] row_prod;
    logic [PROD_W-1:0] slot_full;
    logic              pair_bad;

    assign s_ready = !clear_busy && (!job_valid_reg || job_ready);
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_count_reg <= ITEM_COUNT_RESET;
        end else if (cfg_valid) begin
            item_count_reg <= cfg_data;
        end
    end

    // Slot of (lo, hi) is lo*(2n-lo-1)/2 + (hi-lo-1); the product is always even.
    always_comb begin
        if (32'(item_count_reg) > 32'(MAX_ITEMS)) begin
            n_eff = CFG_W'(MAX_ITEMS);
        end else begin
            n_eff = item_count_reg;
        end
        lo        = (s_first_id < s_second_id) ? s_first_id : s_second_id;
        hi        = (s_first_id < s_second_id) ? s_second_id : s_first_id;
        row_span  = {n_eff, 1'b0} - (CFG_W + 1)'(lo) - (CFG_W + 1)'(1);
        row_prod  = PROD_W'(lo) * PROD_W'(row_span);
        slot_full = (row_prod >> 1) + PROD_W'(hi - lo - ID_W'(1));
        pair_bad  = (s_first_id == s_second_id)
                 || ({1'b0, s_first_id} >= n_eff)
                 || ({1'b0, s_second_id} >= n_eff)
                 || (32'(slot_full) >= 32'(TABLE_DEPTH));
    end

    always_comb begin
        job_valid_next = job_valid_reg;
        tag_next       = tag_reg;
        slot_next      = slot_reg;
        if (accept) begin
            job_valid_next     = 1'b1;
            tag_next.bad       = pair_bad;
            tag_next.increment = s_increment;
            slot_next          = SLOT_W'(slot_full);
        end else if (job_ready) begin
            job_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
        end else begin
            job_valid_reg <= job_valid_next;
        end
        tag_reg  <= tag_next;
        slot_reg <= slot_next;
    end

    assign job_valid = job_valid_reg;
    assign job_tag   = tag_reg;
    assign job_slot  = slot_reg;

endmodule

@@ design/pft_queue.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Pair frequency table job queue
// Two-entry queue that decouples the front end from the back end.
// ---------------------------------------------------------------------------
module pft_queue #(
    parameter int DATA_W = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DATA_W-1:0] in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_data
);
    import pft_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push, pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

@@ design/pft_back.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Pair frequency table back end
// Clears the counter RAM after reset, then runs read-add-write per good job.
// ---------------------------------------------------------------------------
module pft_back #(
    parameter int MAX_ITEMS   = pft_pkg::DEFAULT_MAX_ITEMS,
    parameter int COUNT_WIDTH = pft_pkg::DEFAULT_COUNT_WIDTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // jobs from the queue
    input  logic                   job_valid,
    output logic                   job_ready,
    input  pft_pkg::pft_tag_t      job_tag,
    input  logic [pft_pkg::pft_addr_width(MAX_ITEMS * (MAX_ITEMS - 1) / 2)-1:0] job_slot,
    output logic                   clear_busy,
    // results
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [COUNT_WIDTH-1:0] m_pair_count,
    output logic                   m_saturated,
    output logic                   m_bad_pair
);
    import pft_pkg::*;

    localparam int TABLE_DEPTH = MAX_ITEMS * (MAX_ITEMS - 1) / 2;
    localparam int SLOT_W      = pft_addr_width(TABLE_DEPTH);
    localparam int SUM_W       = ((COUNT_WIDTH > INC_W) ? COUNT_WIDTH : INC_W) + 1;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    pft_back_state_t        state_reg, state_next;
    logic [SLOT_W-1:0]      clr_addr_reg, clr_addr_next;
    logic [SLOT_W-1:0]      slot_reg, slot_next;
    logic [INC_W-1:0]       inc_reg, inc_next;
    logic                   out_valid_reg, out_valid_next;
    logic [COUNT_WIDTH-1:0] out_count_reg, out_count_next;
    logic                   out_sat_reg, out_sat_next;
    logic                   out_bad_reg, out_bad_next;

    logic                   wr_en, rd_en;
    logic [SLOT_W-1:0]      wr_addr;
    logic [COUNT_WIDTH-1:0] wr_data, rd_data;
    logic                   out_free, take, clr_last;
    logic [SUM_W-1:0]       sum;
    logic                   sum_sat;
    logic [COUNT_WIDTH-1:0] sum_clip;

    pft_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (TABLE_DEPTH)
    ) u_counter_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (job_slot),
        .rd_data (rd_data)
    );

    assign out_free = !out_valid_reg || m_ready;
    assign take     = (state_reg == BACK_IDLE) && job_valid && out_free;
    assign clr_last = (clr_addr_reg == SLOT_W'(TABLE_DEPTH - 1));

    // Saturating add: clip when the sum leaves the counter range
    assign sum      = SUM_W'(rd_data) + SUM_W'(inc_reg);
    assign sum_sat  = (sum > SUM_W'(COUNT_MAX));
    assign sum_clip = sum_sat ? COUNT_MAX : sum[COUNT_WIDTH-1:0];

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BACK_CLEAR: begin
                if (clr_last) begin
                    state_next = BACK_IDLE;
                end
            end
            BACK_IDLE: begin
                if (take && !job_tag.bad) begin
                    state_next = BACK_UPDATE;
                end
            end
            BACK_UPDATE: begin
                state_next = BACK_IDLE;
            end
            default: begin
                state_next = BACK_IDLE;
            end
        endcase
    end

    always_comb begin
        clr_addr_next  = clr_addr_reg;
        slot_next      = slot_reg;
        inc_next       = inc_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_count_next = out_count_reg;
        out_sat_next   = out_sat_reg;
        out_bad_next   = out_bad_reg;
        wr_en          = 1'b0;
        wr_addr        = slot_reg;
        wr_data        = sum_clip;
        rd_en          = 1'b0;
        job_ready      = 1'b0;
        clear_busy     = 1'b0;
        case (state_reg)
            BACK_CLEAR: begin
                clear_busy    = 1'b1;
                wr_en         = 1'b1;
                wr_addr       = clr_addr_reg;
                wr_data       = '0;
                clr_addr_next = clr_addr_reg + SLOT_W'(1);
            end
            BACK_IDLE: begin
                job_ready = out_free;
                if (take) begin
                    if (job_tag.bad) begin
                        // Rejected pair: answer at once, leave the table alone
                        out_valid_next = 1'b1;
                        out_count_next = '0;
                        out_sat_next   = 1'b0;
                        out_bad_next   = 1'b1;
                    end else begin
                        rd_en     = 1'b1;
                        slot_next = job_slot;
                        inc_next  = job_tag.increment;
                    end
                end
            end
            BACK_UPDATE: begin
                wr_en          = 1'b1;
                out_valid_next = 1'b1;
                out_count_next = sum_clip;
                out_sat_next   = sum_sat;
                out_bad_next   = 1'b0;
            end
            default: begin
                clear_busy = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BACK_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
        end
        slot_reg      <= slot_next;
        inc_reg       <= inc_next;
        out_count_reg <= out_count_next;
        out_sat_reg   <= out_sat_next;
        out_bad_reg   <= out_bad_next;
    end

    assign m_valid      = out_valid_reg;
    assign m_pair_count = out_count_reg;
    assign m_saturated  = out_sat_reg;
    assign m_bad_pair   = out_bad_reg;

endmodule

@@ design/pair_frequency_table.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Pair frequency table
// Saturating co-occurrence counters for unordered pairs of item ids.
// ---------------------------------------------------------------------------
// After reset the block sweeps its whole counter RAM to zero, one entry a
// cycle; s_ready stays low during the sweep, while configuration writes are
// taken as usual. Then each accepted pair yields exactly one result, in order.
// The front end takes one item a cycle into a two-entry queue while the queue
// has room. The back end handles a good pair in order: it first reads the
// counter from the RAM's registered read port, then adds, writes back and
// loads the result register, and takes no new item until the write-back is
// done; a rejected pair is answered at once, without the RAM read. A result
// passes the front-end job register, the queue and the back end's result
// register. Write item_count only while no item is in flight.
// ---------------------------------------------------------------------------
module pair_frequency_table #(
    parameter int MAX_ITEMS   = pft_pkg::DEFAULT_MAX_ITEMS,
    parameter int COUNT_WIDTH = pft_pkg::DEFAULT_COUNT_WIDTH
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // configuration write channel: item_count
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [pft_pkg::CFG_W-1:0]  cfg_data,
    // input channel
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [pft_pkg::ID_W-1:0]   s_first_id,
    input  logic [pft_pkg::ID_W-1:0]   s_second_id,
    input  logic [pft_pkg::INC_W-1:0]  s_increment,
    // result channel
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [COUNT_WIDTH-1:0]     m_pair_count,
    output logic                       m_saturated,
    output logic                       m_bad_pair
);
    import pft_pkg::*;

    localparam int TABLE_DEPTH = MAX_ITEMS * (MAX_ITEMS - 1) / 2;
    localparam int SLOT_W      = pft_addr_width(TABLE_DEPTH);
    localparam int JOB_W       = $bits(pft_tag_t) + SLOT_W;

    logic              f_valid, f_ready;
    pft_tag_t          f_tag;
    logic [SLOT_W-1:0] f_slot;
    logic              b_valid, b_ready;
    logic [JOB_W-1:0]  b_job;
    pft_tag_t          b_tag;
    logic [SLOT_W-1:0] b_slot;
    logic              clear_busy;

    assign cfg_ready = 1'b1;

    pft_front #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_first_id  (s_first_id),
        .s_second_id (s_second_id),
        .s_increment (s_increment),
        .clear_busy  (clear_busy),
        .job_valid   (f_valid),
        .job_ready   (f_ready),
        .job_tag     (f_tag),
        .job_slot    (f_slot)
    );

    pft_queue #(
        .DATA_W (JOB_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   ({f_tag, f_slot}),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_data  (b_job)
    );

    assign b_tag  = b_job[JOB_W-1:SLOT_W];
    assign b_slot = b_job[SLOT_W-1:0];

    pft_back #(
        .MAX_ITEMS   (MAX_ITEMS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .job_valid    (b_valid),
        .job_ready    (b_ready),
        .job_tag      (b_tag),
        .job_slot     (b_slot),
        .clear_busy   (clear_busy),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pair_count (m_pair_count),
        .m_saturated  (m_saturated),
        .m_bad_pair   (m_bad_pair)
    );

endmodule

@@ design/pft_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Pair frequency table checker
// Port-level assertions on results, bound to the top level.
// ---------------------------------------------------------------------------
`include "pair_frequency_table_macros.svh"

module pft_checker #(
    parameter int COUNT_WIDTH = pft_pkg::DEFAULT_COUNT_WIDTH
) (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic [COUNT_WIDTH-1:0]     m_pair_count,
    input logic                       m_saturated,
    input logic                       m_bad_pair
);
    import pft_pkg::*;

    logic                   bad_out, sat_out, stall_out;
    logic                   bad_clean, sat_clean;
    logic [COUNT_WIDTH+1:0] res_bits;

    assign bad_out   = m_valid && m_bad_pair;
    assign sat_out   = m_valid && m_saturated;
    assign stall_out = m_valid && !m_ready;
    assign bad_clean = (m_pair_count == '0) && !m_saturated;
    assign sat_clean = (&m_pair_count) && !m_bad_pair;
    assign res_bits  = {m_pair_count, m_saturated, m_bad_pair};

    // A rejected pair reports a zero count and no clipping
    `PFT_ASSERT_IMPLY(a_bad_clean, aclk, aresetn, bad_out, bad_clean, "bad pair with data")

    // A clipped add always lands on the counter maximum
    `PFT_ASSERT_IMPLY(a_sat_at_max, aclk, aresetn, sat_out, sat_clean, "clip not at max")

    // Hold a stalled result
    `PFT_ASSERT_NEXT(a_hold, aclk, aresetn, stall_out, m_valid && $stable(res_bits), "stall broken")

endmodule

bind pair_frequency_table pft_checker #(.COUNT_WIDTH(COUNT_WIDTH)) u_pft_checker (.*);
